[design/cst_pkg.sv]
package cst_pkg;

   localparam int SEM_COUNT_DEF  = 16;
   localparam int TASK_COUNT_DEF = 16;

   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_WAIT  = 2'd2,
      KIND_POST  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ERR   = 2'd1,
      ST_BLOCK = 2'd2
   } status_type;

   typedef struct packed {
      kind_type          kind;
      logic [3:0]        sem_id;
      logic signed [7:0] start_count;
      logic [3:0]        task_id;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [3:0] alloc_index;
      logic       wake_valid;
      logic [3:0] wake_task;
   } rsp_type;

   // One table entry as kept in the RAM
   typedef struct packed {
      logic signed [7:0] count;
      logic              waiter_valid;
      logic [3:0]        waiter_task;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic slot_free;
   } stat_type;

endpackage

[design/cst_ram.sv]
module cst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/cst_datapath.sv]
module cst_datapath #(
   parameter int SEM_COUNT  = cst_pkg::SEM_COUNT_DEF,
   parameter int TASK_COUNT = cst_pkg::TASK_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cst_pkg::req_type  req_data,
   input  logic              rsp_ready,
   input  cst_pkg::cmd_type  cmd,
   output cst_pkg::stat_type stat,
   output logic              rsp_valid,
   output cst_pkg::rsp_type  rsp_data
);

   localparam int IDX_W   = $clog2(SEM_COUNT);
   localparam int ENTRY_W = $bits(cst_pkg::entry_type);

   cst_pkg::req_type   req_ff;
   logic [IDX_W-1:0]   free_idx_ff;
   logic               full_ff;
   logic [SEM_COUNT-1:0] in_use_ff, in_use_in;
   logic               rsp_valid_ff;
   cst_pkg::rsp_type   rsp_ff, rsp_in;

   logic [IDX_W-1:0]   free_idx;
   logic               free_found;
   logic [ENTRY_W-1:0] rd_data;
   cst_pkg::entry_type entry_q, wr_entry;
   logic [IDX_W-1:0]   sem_idx, wr_addr;
   logic               id_ok, used, wr_en;

   // Lowest free entry, taken when the request is captured
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SEM_COUNT - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   cst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SEM_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.commit && wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.capture),
      .rd_addr (IDX_W'(req_data.sem_id)),
      .rd_data (rd_data)
   );

   assign entry_q = cst_pkg::entry_type'(rd_data);
   assign sem_idx = IDX_W'(req_ff.sem_id);
   assign id_ok   = int'(req_ff.sem_id) < SEM_COUNT;
   assign used    = id_ok && in_use_ff[sem_idx];

   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = sem_idx;
      wr_entry  = entry_q;
      in_use_in = in_use_ff;
      rsp_in    = '0;
      rsp_in.status = cst_pkg::ST_OK;
      case (req_ff.kind)
         cst_pkg::KIND_ALLOC: begin
            if (full_ff) begin
               rsp_in.status = cst_pkg::ST_ERR;
            end else begin
               rsp_in.alloc_index     = 4'(free_idx_ff);
               wr_en                  = 1'b1;
               wr_addr                = free_idx_ff;
               wr_entry.count         = req_ff.start_count;
               wr_entry.waiter_valid  = 1'b0;
               wr_entry.waiter_task   = '0;
               in_use_in[free_idx_ff] = 1'b1;
            end
         end
         cst_pkg::KIND_FREE: begin
            if (id_ok) begin
               in_use_in[sem_idx] = 1'b0;
            end
         end
         cst_pkg::KIND_WAIT: begin
            if (!used) begin
               rsp_in.status = cst_pkg::ST_ERR;
            end else if (!entry_q.count[7] && entry_q.count != 8'sd0) begin
               wr_en          = 1'b1;
               wr_entry.count = entry_q.count - 8'sd1;
            end else begin
               wr_en                 = 1'b1;
               wr_entry.waiter_valid = 1'b1;
               wr_entry.waiter_task  = req_ff.task_id;
               rsp_in.status         = cst_pkg::ST_BLOCK;
            end
         end
         cst_pkg::KIND_POST: begin
            if (!used) begin
               rsp_in.status = cst_pkg::ST_ERR;
            end else begin
               // drop a waiter outside the task range without reporting it
               if (entry_q.waiter_valid && int'(entry_q.waiter_task) < TASK_COUNT) begin
                  rsp_in.wake_valid = 1'b1;
                  rsp_in.wake_task  = entry_q.waiter_task;
               end
               wr_en                 = 1'b1;
               wr_entry.count        = entry_q.count + 8'sd1;
               wr_entry.waiter_valid = 1'b0;
               wr_entry.waiter_task  = '0;
            end
         end
         default: begin
            rsp_in.status = cst_pkg::ST_ERR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            in_use_ff    <= in_use_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff      <= req_data;
         free_idx_ff <= free_idx;
         full_ff     <= !free_found;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_ff;

   a_commit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   a_alloc_marks: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && req_ff.kind == cst_pkg::KIND_ALLOC && !full_ff)
      |=> in_use_ff[$past(free_idx_ff)])
      else $error("allocated entry not marked in use");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.status == cst_pkg::ST_OK ||
                        rsp_ff.status == cst_pkg::ST_ERR ||
                        rsp_ff.status == cst_pkg::ST_BLOCK))
      else $error("bad status code on result");

endmodule

[design/cst_ctrl.sv]
module cst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  cst_pkg::stat_type stat,
   output logic              req_ready,
   output cst_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold until the result register can take the outcome
            cmd.commit = stat.slot_free;
            if (stat.slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/counting_semaphore_table_unit.sv]
// Channel   Ports                          Direction  Beat
// request   req_valid/req_ready/req_data   in         one operation
// response  rsp_valid/rsp_ready/rsp_data   out        one result per operation
//
// Each request is handled as capture plus table read, then update plus
// result load; the registered read of the entry RAM sets this split.
// A new request is taken while the previous result still waits in the output
// register; a stalled result holds the update cycle until the register frees.
// Reset (synchronous) clears every in-use mark and the controller; entry data
// is only used after an allocate has written it, so the RAM needs no clearing.
module counting_semaphore_table_unit #(
   parameter int SEM_COUNT  = cst_pkg::SEM_COUNT_DEF,
   parameter int TASK_COUNT = cst_pkg::TASK_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cst_pkg::rsp_type rsp_data
);

   cst_pkg::cmd_type  cmd;
   cst_pkg::stat_type stat;

   // Sequence capture and commit
   cst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // Hold the in-use marks, the entry RAM and the result register
   cst_datapath #(
      .SEM_COUNT  (SEM_COUNT),
      .TASK_COUNT (TASK_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/counting_semaphore_table_unit_test.sv]
`timescale 1ns / 100ps

module counting_semaphore_table_unit_test;

   localparam int SEMS  = cst_pkg::SEM_COUNT_DEF;
   localparam int TASKS = cst_pkg::TASK_COUNT_DEF;

   // Shadow copy of the semaphore table plus the queue of results the block owes us.
   class sem_table_shadow;
      bit                in_use[SEMS];
      logic signed [7:0] count[SEMS];
      bit                waiter_valid[SEMS];
      logic [3:0]        waiter_task[SEMS];
      cst_pkg::rsp_type  results_owed[$];
      int unsigned       failures;

      function new();
         foreach (in_use[i]) begin
            in_use[i]       = 1'b0;
            count[i]        = '0;
            waiter_valid[i] = 1'b0;
            waiter_task[i]  = '0;
         end
         failures = 0;
      endfunction

      // Apply one request to the shadow table and return the result it earns.
      function cst_pkg::rsp_type run_sem_op(cst_pkg::req_type r);
         cst_pkg::rsp_type res;
         int      id;
         int      slot;
         res  = '0;
         id   = r.sem_id;
         slot = -1;
         case (r.kind)
            cst_pkg::KIND_ALLOC: begin
               for (int i = 0; i < SEMS; i++)
                  if (!in_use[i] && slot < 0) slot = i;
               if (slot < 0) begin
                  res.status = cst_pkg::ST_ERR;
               end else begin
                  in_use[slot]       = 1'b1;
                  count[slot]        = r.start_count;
                  waiter_valid[slot] = 1'b0;
                  waiter_task[slot]  = '0;
                  res.alloc_index    = 4'(slot);
               end
            end
            cst_pkg::KIND_FREE: begin
               if (id < SEMS) in_use[id] = 1'b0;
            end
            default: begin
               if (id >= SEMS || !in_use[id]) begin
                  res.status = cst_pkg::ST_ERR;
               end else if (r.kind == cst_pkg::KIND_WAIT) begin
                  if (count[id] > 0) begin
                     count[id] = count[id] - 8'sd1;
                  end else begin
                     waiter_valid[id] = 1'b1;
                     waiter_task[id]  = r.task_id;
                     res.status       = cst_pkg::ST_BLOCK;
                  end
               end else begin
                  if (waiter_valid[id] && waiter_task[id] < TASKS) begin
                     res.wake_valid = 1'b1;
                     res.wake_task  = waiter_task[id];
                  end
                  waiter_valid[id] = 1'b0;
                  waiter_task[id]  = '0;
                  count[id]        = count[id] + 8'sd1;   // wraps 127 -> -128
               end
            end
         endcase
         return res;
      endfunction

      function void note_request(cst_pkg::req_type r);
         results_owed.push_back(run_sem_op(r));
      endfunction

      function void check_result(cst_pkg::rsp_type got);
         cst_pkg::rsp_type want;
         if (results_owed.size() == 0) begin
            $error("response beat with no request outstanding");
            failures++;
            return;
         end
         want = results_owed.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            failures++;
         end
         if (got.alloc_index !== want.alloc_index) begin
            $error("alloc_index: expected %0d, actual %0d", want.alloc_index, got.alloc_index);
            failures++;
         end
         if (got.wake_valid !== want.wake_valid) begin
            $error("wake_valid: expected %0d, actual %0d", want.wake_valid, got.wake_valid);
            failures++;
         end
         if (got.wake_task !== want.wake_task) begin
            $error("wake_task: expected %0d, actual %0d", want.wake_task, got.wake_task);
            failures++;
         end
      endfunction

      function int owed();
         return results_owed.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   cst_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   cst_pkg::rsp_type rsp_data;

   sem_table_shadow sb = new();

   // Idle knobs, in percent; the main sequence changes them per phase.
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   // Long receiver hold-off: main raises the request, the receiver counts it out.
   bit rsp_hold_req   = 1'b0;
   int rsp_hold_left  = 0;

   counting_semaphore_table_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Receiver: drive ready at the falling edge. Exactly one assignment per edge, so a
   // long hold-off never collides with the random stall decision.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_left--;
         end else if (rsp_hold_req) begin
            rsp_hold_req  = 1'b0;
            rsp_hold_left = 63;
            rsp_ready     <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Result monitor: sample the response handshake at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         sb.check_result(rsp_data);
   end

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic cst_pkg::req_type make_req(cst_pkg::kind_type k, int id, int init,
                                                 int tid);
      cst_pkg::req_type r;
      r.kind        = k;
      r.sem_id      = 4'(id);
      r.start_count = 8'(init);
      r.task_id     = 4'(tid);
      return r;
   endfunction

   // Build one random request. Most target live entries; start counts favour small and extreme
   // values so waits block and posts wake; the table fill level steers allocate versus free.
   function automatic cst_pkg::req_type pick_request();
      cst_pkg::req_type r;
      int      used_ids[$];
      int      alloc_w;
      int      free_w;
      int      p;
      for (int i = 0; i < SEMS; i++)
         if (sb.in_use[i]) used_ids.push_back(i);
      r.task_id = 4'($urandom_range(15));
      r.sem_id  = 4'($urandom_range(15));
      case ($urandom_range(7))
         0, 1:    r.start_count = 8'($urandom_range(3));
         2:       r.start_count = 8'($urandom_range(255, 252));   // small negatives
         3:       r.start_count = 8'($urandom_range(127, 126));   // near the wrap
         4:       r.start_count = 8'($urandom_range(129, 128));   // most negative
         default: r.start_count = 8'($urandom_range(255));
      endcase
      // Noise: one in ten is entirely random.
      if ($urandom_range(9) == 0) begin
         r.kind = cst_pkg::kind_type'($urandom_range(3));
         return r;
      end
      alloc_w = (used_ids.size() < 4) ? 40 : (used_ids.size() > 12) ? 8 : 20;
      free_w  = (used_ids.size() > 12) ? 30 : (used_ids.size() < 4) ? 4 : 12;
      p = $urandom_range(99);
      if (p < alloc_w)
         r.kind = cst_pkg::KIND_ALLOC;
      else if (p < alloc_w + free_w)
         r.kind = cst_pkg::KIND_FREE;
      else if ($urandom_range(1) == 0)
         r.kind = cst_pkg::KIND_WAIT;
      else
         r.kind = cst_pkg::KIND_POST;
      if (r.kind != cst_pkg::KIND_ALLOC && used_ids.size() > 0 && $urandom_range(6) != 0)
         r.sem_id = 4'(used_ids[$urandom_range(used_ids.size() - 1)]);
      return r;
   endfunction

   // Offer one beat: idle at the falling edge as the knob says, then hold valid and
   // payload until the rising edge that sees ready. Valid is left high on return so
   // the next beat can follow back to back.
   task automatic send_req(cst_pkg::req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      sb.note_request(r);
   endtask

   // Drop valid and hold until every owed result has come back.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.owed() != 0) @(posedge clock);
   endtask

   initial begin
      cst_pkg::req_type directed[$];

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: unused entries, wrap of the count, waiter replacement and wake,
      // reuse of a freed entry, then fill the table and overflow it.
      directed.push_back(make_req(cst_pkg::KIND_WAIT,  5,    0,  3));   // wait on unused
      directed.push_back(make_req(cst_pkg::KIND_FREE,  3,    0,  0));   // free of unused
      directed.push_back(make_req(cst_pkg::KIND_ALLOC, 0,  127,  0));   // entry 0, top
      directed.push_back(make_req(cst_pkg::KIND_POST,  0,    0,  0));   // 127 wraps
      directed.push_back(make_req(cst_pkg::KIND_WAIT,  0,    0, 15));   // negative blocks
      directed.push_back(make_req(cst_pkg::KIND_WAIT,  0,    0,  0));   // replaces waiter
      directed.push_back(make_req(cst_pkg::KIND_POST,  0,    0,  0));   // wakes task 0
      directed.push_back(make_req(cst_pkg::KIND_ALLOC, 0, -128,  0));   // entry 1
      directed.push_back(make_req(cst_pkg::KIND_ALLOC, 0,    1,  0));   // entry 2
      directed.push_back(make_req(cst_pkg::KIND_WAIT,  2,    0,  9));   // last unit
      directed.push_back(make_req(cst_pkg::KIND_WAIT,  2,    0, 10));   // zero blocks
      directed.push_back(make_req(cst_pkg::KIND_POST,  2,    0,  0));   // wakes task 10
      directed.push_back(make_req(cst_pkg::KIND_FREE,  1,    0,  0));
      directed.push_back(make_req(cst_pkg::KIND_POST,  1,    0,  0));   // post on freed
      directed.push_back(make_req(cst_pkg::KIND_ALLOC, 0,    0,  0));   // reuses entry 1
      for (int i = 3; i < SEMS; i++)
         directed.push_back(make_req(cst_pkg::KIND_ALLOC, 0, $urandom_range(255), 0));
      directed.push_back(make_req(cst_pkg::KIND_ALLOC, 0,    5,  0));   // table full
      directed.push_back(make_req(cst_pkg::KIND_FREE, 15,    0, 15));
      foreach (directed[i]) send_req(directed[i]);
      wait_for_results();

      // Random part in idle phases: none, sender idle, receiver stalling, both.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 69; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 69; end
            default: begin send_idle_pct = 20; rsp_stall_pct = 20; end
         endcase
         repeat (120) send_req(pick_request());
         wait_for_results();   // sender pauses until the block has drained
      end

      // Back-pressure: hold the receiver off for a long stretch while requests keep
      // coming, so the block fills and stalls its input.
      send_idle_pct = 0;
      rsp_stall_pct = 10;
      rsp_hold_req  = 1'b1;
      repeat (40) send_req(pick_request());
      wait_for_results();

      repeat (10) @(posedge clock);
      if (sb.failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
